// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold at that edge.
`define QTLE_AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qtle assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold at the following edge.
`define QTLE_AST_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qtle assertion failed");

`endif

// ===== src/qtle_pkg.sv =====
`default_nettype none

package qtle_pkg;

	// Default table geometry.
	localparam int NUM_STATES_DEF  = 256;
	localparam int NUM_ACTIONS_DEF = 8;

	// Field widths of the channels.
	localparam int STATE_IDX_W = 8;
	localparam int ACTION_W    = 4;
	localparam int REWARD_W    = 16;
	localparam int RAND_W      = 16;
	localparam int Q_W         = 32;
	localparam int RATE_W      = 16;
	localparam int CFG_IDX_W   = 2;

	// Widest modulus handed to the reduction helper (up to 8191 states).
	localparam int MOD_W = 13;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_EXPLORE  = 2'd0;
	localparam cfg_idx_t REG_LEARN    = 2'd1;
	localparam cfg_idx_t REG_DISCOUNT = 2'd2;

	// Register reset values, all Q0.16.
	localparam logic [RATE_W-1:0] EXPLORE_RST  = 16'd6554;
	localparam logic [RATE_W-1:0] LEARN_RST    = 16'd6554;
	localparam logic [RATE_W-1:0] DISCOUNT_RST = 16'd58982;

	// Request kinds.
	localparam logic REQ_SELECT = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	// Eight restoring compare-and-subtract steps of x modulo m. The upper pass
	// handles multiples m<<15 down to m<<8, the lower pass m<<7 down to m.
	// Two passes leave any 16-bit value reduced below m.
	function automatic logic [15:0] mod_half(input logic [15:0] x,
		input logic [MOD_W-1:0] m, input logic upper);
		logic [31:0] r;
		logic [31:0] d;
		int k;
		r = {16'd0, x};
		for (k = 7; k >= 0; k--) begin
			d = {19'd0, m} << (upper ? k + 8 : k);
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/qtle_if.sv =====
`default_nettype none

// Request channel: one beat is one select or update request.
interface qtle_req_if;
	import qtle_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [STATE_IDX_W-1:0]        state_index;
	logic [ACTION_W-1:0]           action_index;
	logic [STATE_IDX_W-1:0]        next_state;
	logic signed [REWARD_W-1:0]    reward;
	logic [RAND_W-1:0]             random_draw;
	logic [RAND_W-1:0]             random_action;

	modport source (output valid, req_type, state_index, action_index, next_state,
		reward, random_draw, random_action, input ready);
	modport sink (input valid, req_type, state_index, action_index, next_state,
		reward, random_draw, random_action, output ready);
endinterface

// Response channel: one beat per request.
interface qtle_rsp_if;
	import qtle_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [ACTION_W-1:0]    chosen_action;
	logic                   explored;
	logic signed [Q_W-1:0]  q_value;
	logic                   saturated;

	modport source (output valid, chosen_action, explored, q_value, saturated,
		input ready);
	modport sink (input valid, chosen_action, explored, q_value, saturated,
		output ready);
endinterface

// Configuration write channel.
interface qtle_cfg_if;
	import qtle_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RATE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/qtle_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module qtle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/q_table_learning_engine_core.sv =====
// Tabular Q-learning engine with epsilon-greedy action choice, fixed point.
// Channels: req (sink) takes one request per beat, rsp (source) gives one result
// beat per request, cfg (sink) writes epsilon, alpha and gamma; cfg is always
// ready and must only be written while no request is in flight.
// A select request returns the first greedy action of the state's row when the
// draw is above epsilon, else random_action modulo NUM_ACTIONS. An update
// request rewrites Q(s,a) with the saturated temporal-difference step.
// Requests are taken one at a time: a new request beat is taken only once the
// previous result has gone to the output register. The time per request is
// set by the row scan: the table sits in one RAM with a single read port, so
// the row is read one entry per cycle, and the update then runs two products
// through one shared multiplier.
// Reset sets the sequencer, configuration and output-valid registers at once,
// then sweeps zeros through all NUM_STATES*NUM_ACTIONS table entries (2048 by
// default), one entry per cycle; req is held not ready during the sweep.
// A finished result waits in the output register when rsp stalls; a new
// request is still taken meanwhile and its result is held until the output
// register frees up.
`default_nettype none

module q_table_learning_engine_core #(
	parameter int NUM_STATES  = qtle_pkg::NUM_STATES_DEF,
	parameter int NUM_ACTIONS = qtle_pkg::NUM_ACTIONS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qtle_cfg_if.sink   cfg,
	qtle_req_if.sink   req,
	qtle_rsp_if.source rsp
);
	import qtle_pkg::*;

	localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = $clog2(NUM_STATES);
	localparam int COL_W  = $clog2(NUM_ACTIONS);
	localparam int CNT_W  = $clog2(NUM_ACTIONS + 2);

	// Sequencer states.
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RED0  = 4'd2;
	localparam logic [3:0] ST_RED1  = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_MULG  = 4'd5;
	localparam logic [3:0] ST_DIFF  = 4'd6;
	localparam logic [3:0] ST_MULA  = 4'd7;
	localparam logic [3:0] ST_SAT   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0] state_q;

	// Configuration registers.
	logic [RATE_W-1:0] eps_q;
	logic [RATE_W-1:0] alpha_q;
	logic [RATE_W-1:0] gamma_q;

	// Request held for the duration of its work.
	logic                       type_q;
	logic                       explore_q;
	logic [STATE_IDX_W-1:0]     sidx_q;
	logic [STATE_IDX_W-1:0]     nidx_q;
	logic [ACTION_W-1:0]        aidx_q;
	logic [RAND_W-1:0]          ract_q;
	logic signed [REWARD_W-1:0] reward_q;

	// Scan bookkeeping and datapath registers.
	logic [ADDR_W-1:0]      clr_q;
	logic [CNT_W-1:0]       iss_q;
	logic                   rv_q;
	logic [CNT_W-1:0]       rk_q;
	logic signed [Q_W-1:0]  best_val_q;
	logic [COL_W-1:0]       best_idx_q;
	logic signed [Q_W-1:0]  qsa_q;
	logic signed [50:0]     prod_q;
	logic signed [33:0]     diff_q;
	logic                   sat_q;

	// Output register.
	logic                   rsp_valid_q;
	logic [ACTION_W-1:0]    rsp_act_q;
	logic                   rsp_expl_q;
	logic signed [Q_W-1:0]  rsp_q_q;
	logic                   rsp_sat_q;

	// RAM connections.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [Q_W-1:0]    ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [Q_W-1:0]    ram_rdata;

	logic                   req_fire;
	logic                   explore_sel;
	logic [CNT_W-1:0]       n_issue;
	logic [ROW_W-1:0]       s_row;
	logic [ROW_W-1:0]       n_row;
	logic [ADDR_W-1:0]      sa_addr;
	logic                   red_upper;
	logic signed [16:0]     mul_a;
	logic signed [33:0]     mul_b;
	logic signed [50:0]     product;
	logic signed [34:0]     prod_hi;
	logic signed [35:0]     diff_sum;
	logic signed [36:0]     nv;
	logic signed [Q_W-1:0]  nv_clamped;
	logic                   nv_sat;
	logic                   scan_done;
	logic                   out_free;

	qtle_ram #(
		.WIDTH(Q_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The user must change the configuration registers only while the engine is idle; the block does not enforce it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= EXPLORE_RST;
			alpha_q <= LEARN_RST;
			gamma_q <= DISCOUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_EXPLORE:  eps_q   <= cfg.data;
				REG_LEARN:    alpha_q <= cfg.data;
				REG_DISCOUNT: gamma_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// One request is worked on at a time. Since the write-back of an update
	// lands in the RAM before the sequencer returns to idle, a later request
	// always reads the updated entry and no forwarding is needed.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	// Exploring selects read a single entry; greedy selects scan the row of the
	// current state; updates scan the row of the next state and then read Q(s,a).
	assign explore_sel = (type_q == REQ_SELECT) && explore_q;
	always_comb begin
		if (explore_sel) begin
			n_issue = CNT_W'(1);
		end else if (type_q == REQ_SELECT) begin
			n_issue = CNT_W'(NUM_ACTIONS);
		end else begin
			n_issue = CNT_W'(NUM_ACTIONS + 1);
		end
	end

	assign s_row   = ROW_W'(sidx_q);
	assign n_row   = ROW_W'(nidx_q);
	assign sa_addr = ADDR_W'(ADDR_W'(s_row) * ADDR_W'(NUM_ACTIONS)) + ADDR_W'(COL_W'(aidx_q));

	always_comb begin
		ram_re    = (state_q == ST_SCAN) && (iss_q < n_issue);
		if (explore_sel) begin
			ram_raddr = ADDR_W'(ADDR_W'(s_row) * ADDR_W'(NUM_ACTIONS))
				+ ADDR_W'(COL_W'(ract_q));
		end else if (iss_q < CNT_W'(NUM_ACTIONS)) begin
			ram_raddr = ADDR_W'(ADDR_W'((type_q == REQ_UPDATE) ? n_row : s_row)
				* ADDR_W'(NUM_ACTIONS)) + ADDR_W'(COL_W'(iss_q));
		end else begin
			ram_raddr = sa_addr;
		end
	end

	assign scan_done = rv_q && (rk_q == n_issue - CNT_W'(1));

	// One shared multiplier: gamma times max Q(s',*), then alpha times the
	// temporal difference. The rates are unsigned, so they enter with a zero
	// sign bit.
	assign mul_a   = $signed({1'b0, (state_q == ST_MULG) ? gamma_q : alpha_q});
	assign mul_b   = (state_q == ST_MULG) ? 34'(best_val_q) : diff_q;
	assign product = mul_a * mul_b;

	// An arithmetic shift by 16 rounds toward minus infinity, as required.
	assign prod_hi  = prod_q[50:16];
	assign diff_sum = 36'($signed({reward_q, 8'd0})) + 36'(prod_hi) - 36'(qsa_q);
	assign nv       = 37'(qsa_q) + 37'(prod_hi);

	always_comb begin
		if (nv > 37'sd2147483647) begin
			nv_clamped = 32'sh7fffffff;
			nv_sat     = 1'b1;
		end else if (nv < -37'sd2147483648) begin
			nv_clamped = 32'sh80000000;
			nv_sat     = 1'b1;
		end else begin
			nv_clamped = 32'(nv);
			nv_sat     = 1'b0;
		end
	end

	// The reset sweep and the update write-back share the write port.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_SAT);
			ram_waddr = sa_addr;
			ram_wdata = nv_clamped;
		end
	end

	assign red_upper = (state_q == ST_RED0);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			iss_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= ram_re;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_RED0;
					end
				end
				ST_RED0: state_q <= ST_RED1;
				ST_RED1: begin
					iss_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (ram_re) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= (type_q == REQ_UPDATE) ? ST_MULG : ST_OUT;
					end
				end
				ST_MULG: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MULA;
				ST_MULA: state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and the two reduction passes. Out-of-range states and
	// actions wrap modulo the table size along each axis.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_q    <= req.req_type;
			explore_q <= !(req.random_draw > eps_q);
			sidx_q    <= req.state_index;
			nidx_q    <= req.next_state;
			aidx_q    <= req.action_index;
			ract_q    <= req.random_action;
			reward_q  <= req.reward;
		end else if (state_q == ST_RED0 || state_q == ST_RED1) begin
			sidx_q <= STATE_IDX_W'(mod_half(16'(sidx_q), MOD_W'(NUM_STATES), red_upper));
			nidx_q <= STATE_IDX_W'(mod_half(16'(nidx_q), MOD_W'(NUM_STATES), red_upper));
			aidx_q <= ACTION_W'(mod_half(16'(aidx_q), MOD_W'(NUM_ACTIONS), red_upper));
			ract_q <= mod_half(ract_q, MOD_W'(NUM_ACTIONS), red_upper);
		end
	end

	// Scan results and the update arithmetic. The first maximum of the row is
	// kept, so a tie never replaces the earlier action.
	always_ff @(posedge clk) begin
		rk_q <= iss_q;
		if (rv_q) begin
			if (explore_sel) begin
				best_val_q <= $signed(ram_rdata);
				best_idx_q <= COL_W'(ract_q);
			end else if (rk_q < CNT_W'(NUM_ACTIONS)) begin
				if (rk_q == '0 || $signed(ram_rdata) > best_val_q) begin
					best_val_q <= $signed(ram_rdata);
					best_idx_q <= COL_W'(rk_q);
				end
			end else begin
				qsa_q <= $signed(ram_rdata);
			end
		end
		if (state_q == ST_MULG || state_q == ST_MULA) begin
			prod_q <= product;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= 34'(diff_sum);
		end
		if (state_q == ST_SAT) begin
			best_val_q <= nv_clamped;
			sat_q      <= nv_sat;
		end
	end

	// Output register: a result beat waits here while rsp is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			rsp_act_q  <= (type_q == REQ_SELECT) ? ACTION_W'(best_idx_q) : '0;
			rsp_expl_q <= explore_sel;
			rsp_q_q    <= best_val_q;
			rsp_sat_q  <= (type_q == REQ_UPDATE) && sat_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.chosen_action = rsp_act_q;
	assign rsp.explored      = rsp_expl_q;
	assign rsp.q_value       = rsp_q_q;
	assign rsp.saturated     = rsp_sat_q;

endmodule

`default_nettype wire

// ===== src/qtle_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module qtle_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [3:0]  rsp_chosen_action,
	input wire logic        rsp_explored,
	input wire logic [31:0] rsp_q_value,
	input wire logic        rsp_saturated
);

	// Requests taken but whose result beat has not yet been delivered.
	logic [1:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	// The engine works on one request at a time.
	`QTLE_AST_NXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	// At most one finished result may be waiting when a new request is taken.
	`QTLE_AST_IMP(a_pending_bound, clk, arst_n, req_valid && req_ready, pending_q <= 2'd1)

	// No result beat without a request behind it.
	`QTLE_AST_IMP(a_no_spurious, clk, arst_n, rsp_valid, pending_q != 2'd0)

	// Saturation only comes from updates, which report no action and no exploring.
	`QTLE_AST_IMP(a_sat_is_update, clk, arst_n, rsp_valid && rsp_saturated,
		!rsp_explored && rsp_chosen_action == 4'd0)

	// A stalled result beat holds its value.
	`QTLE_AST_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_q_value))

endmodule

bind q_table_learning_engine_core qtle_port_checks u_qtle_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_chosen_action(rsp.chosen_action),
	.rsp_explored     (rsp.explored),
	.rsp_q_value      (rsp.q_value),
	.rsp_saturated    (rsp.saturated)
);

`default_nettype wire
